// ===== rtl/core/rswf_pkg.sv =====
// Package: constants, verdict codes and shared types for the receive window filter.
`default_nettype none
package rswf_pkg;

  localparam int MAX_PACKET_BYTES = 2048;
  localparam int WINDOW_SIZE      = 32;
  localparam int HEADER_BYTES     = 16;

  localparam int PLEN_W  = 12;
  localparam int PROTO_W = 32;
  localparam int SEQ_W   = 16;
  localparam int TAG_W   = 16;
  localparam int PAY_W   = 16;
  localparam int CNT_W   = 32;
  localparam int ACK_W   = 32;
  localparam int LEN_W   = 17;
  localparam int SH_W    = $clog2(WINDOW_SIZE + 1);

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 144;

  localparam logic [SEQ_W-1:0] SEQ_HALF = SEQ_W'(1) << (SEQ_W - 1);

  typedef enum logic [2:0] {
    V_DELIVER        = 3'd0,
    V_KEEPALIVE      = 3'd1,
    V_RELIABLE       = 3'd2,
    V_DUPLICATE      = 3'd3,
    V_TOO_OLD        = 3'd4,
    V_MALFORMED      = 3'd5,
    V_WRONG_PROTOCOL = 3'd6,
    V_WRONG_PEER     = 3'd7
  } verdict_t;

  typedef struct packed {
    logic     pass;
    verdict_t verdict;
  } chk_t;

  typedef struct packed {
    logic     ok;
    verdict_t verdict;
  } win_res_t;

endpackage
`default_nettype wire

// ===== rtl/core/rswf_check.sv =====
// Header checks: length, protocol id, peer and payload length; holds protocol id register.
`default_nettype none
module rswf_check
  import rswf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [PROTO_W-1:0] cfg_wdata,
  input  wire logic [PLEN_W-1:0]  packet_length,
  input  wire logic [PROTO_W-1:0] header_protocol,
  input  wire logic               peer_match,
  input  wire logic [PAY_W-1:0]   payload_length,
  output chk_t                    chk
);

  logic [PROTO_W-1:0] exp_proto_r;
  logic [LEN_W-1:0]   plen_ext;
  logic [LEN_W-1:0]   need_len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_proto_r <= '0;
    end else if (cfg_we) begin
      exp_proto_r <= cfg_wdata;
    end
  end

  assign plen_ext = LEN_W'(packet_length);
  assign need_len = LEN_W'(HEADER_BYTES) + LEN_W'(payload_length);

  always_comb begin
    chk.pass    = 1'b0;
    chk.verdict = V_MALFORMED;
    if (plen_ext < LEN_W'(HEADER_BYTES) || plen_ext > LEN_W'(MAX_PACKET_BYTES)) begin
      chk.verdict = V_MALFORMED;
    end else if (header_protocol != exp_proto_r) begin
      chk.verdict = V_WRONG_PROTOCOL;
    end else if (!peer_match) begin
      chk.verdict = V_WRONG_PEER;
    end else if (need_len > plen_ext) begin
      chk.verdict = V_MALFORMED;
    end else begin
      chk.pass    = 1'b1;
      chk.verdict = V_DELIVER;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/rswf_window.sv =====
// Sequence window state, bitmap fold and the wrapping packet counters.
`default_nettype none
module rswf_window
  import rswf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             upd,
  input  wire logic             pass,
  input  wire logic [SEQ_W-1:0] seq,
  output win_res_t              res,
  output logic [SEQ_W-1:0]      newest,
  output logic [ACK_W-1:0]      ack_map,
  output logic [CNT_W-1:0]      rx_cnt,
  output logic [CNT_W-1:0]      dup_cnt,
  output logic [CNT_W-1:0]      old_cnt
);

  logic                   started_r, started_nxt;
  logic [SEQ_W-1:0]       newest_r, newest_nxt;
  logic [WINDOW_SIZE-1:0] bitmap_r, bitmap_nxt;
  logic [CNT_W-1:0]       rx_r, dup_r, old_r;
  logic [CNT_W-1:0]       rx_nxt, dup_nxt, old_nxt;

  logic [SEQ_W-1:0]       fwd, back;
  logic                   is_newer;
  logic [SH_W-1:0]        fwd_sh, back_sh;
  logic [WINDOW_SIZE-1:0] back_bit;

  assign fwd      = seq - newest_r;
  assign back     = newest_r - seq;
  assign is_newer = (fwd != '0 && fwd < SEQ_HALF) || (fwd == SEQ_HALF && seq > newest_r);
  assign fwd_sh   = fwd[SH_W-1:0];
  assign back_sh  = back[SH_W-1:0];
  assign back_bit = WINDOW_SIZE'(1) << (back_sh - SH_W'(1));

  always_comb begin
    started_nxt = started_r;
    newest_nxt  = newest_r;
    bitmap_nxt  = bitmap_r;
    rx_nxt      = rx_r;
    dup_nxt     = dup_r;
    old_nxt     = old_r;
    res.ok      = 1'b1;
    res.verdict = V_DELIVER;
    if (pass) begin
      rx_nxt = rx_r + CNT_W'(1);
      if (!started_r) begin
        started_nxt = 1'b1;
        newest_nxt  = seq;
        bitmap_nxt  = '0;
      end else if (is_newer) begin
        newest_nxt = seq;
        if (fwd > SEQ_W'(WINDOW_SIZE)) begin
          bitmap_nxt = '0;
        end else begin
          bitmap_nxt = (bitmap_r << fwd_sh) | (WINDOW_SIZE'(1) << (fwd_sh - SH_W'(1)));
        end
      end else if (fwd == '0) begin
        dup_nxt     = dup_r + CNT_W'(1);
        res.ok      = 1'b0;
        res.verdict = V_DUPLICATE;
      end else if (back > SEQ_W'(WINDOW_SIZE)) begin
        old_nxt     = old_r + CNT_W'(1);
        res.ok      = 1'b0;
        res.verdict = V_TOO_OLD;
      end else if ((bitmap_r & back_bit) != '0) begin
        dup_nxt     = dup_r + CNT_W'(1);
        res.ok      = 1'b0;
        res.verdict = V_DUPLICATE;
      end else begin
        bitmap_nxt = bitmap_r | back_bit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      newest_r  <= '0;
      bitmap_r  <= '0;
      rx_r      <= '0;
      dup_r     <= '0;
      old_r     <= '0;
    end else if (upd) begin
      started_r <= started_nxt;
      newest_r  <= newest_nxt;
      bitmap_r  <= bitmap_nxt;
      rx_r      <= rx_nxt;
      dup_r     <= dup_nxt;
      old_r     <= old_nxt;
    end
  end

  assign newest  = newest_r;
  assign ack_map = ACK_W'(bitmap_r);
  assign rx_cnt  = rx_r;
  assign dup_cnt = dup_r;
  assign old_cnt = old_r;

endmodule
`default_nettype wire

// ===== rtl/core/receive_sequence_window_filter.sv =====
// Top level: input register, header checks, window fold and result register.
//
// One packet header enters on the in_ stream per transfer and one verdict leaves on
// the out_ stream per header, in order. The header is captured in an input register;
// the checks and the window fold run on it combinationally, and the verdict is
// loaded into the result register while the window state and counters update at the
// same edge; that load waits while a held result is stalled. out_tvalid rises with
// the load into the result register; throughput is one header per cycle while
// out_tready stays high. The window and counter registers themselves drive the ack
// and count fields, since they change only when a new verdict is loaded.
// When the receiver stalls, the result holds and one more header waits in the input
// register; in_tready drops only while both are full.
// Synchronous reset clears the window, counters, protocol id and both valid flags.
// cfg_we writes the expected protocol id; write it only while no header is in flight.
`default_nettype none
module receive_sequence_window_filter
  import rswf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [PROTO_W-1:0]    cfg_wdata,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // packet_length[11:0], header_protocol[43:12], sequence_req[59:44],
  // reliable_tag[75:60], payload_length[91:76], zero[95:92]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // peer_match[0]
  input  wire logic                  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // ack_newest[15:0], ack_bitmap[47:16], received_count[79:48],
  // duplicate_count[111:80], too_old_count[143:112]
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // verdict[2:0]
  output logic [2:0]                 out_tuser
);

  logic                 in_valid_r;
  logic [PLEN_W-1:0]    plen_r;
  logic [PROTO_W-1:0]   proto_r;
  logic [SEQ_W-1:0]     seq_r;
  logic [TAG_W-1:0]     tag_r;
  logic [PAY_W-1:0]     pay_r;
  logic                 peer_r;
  logic                 out_valid_r;
  verdict_t             verdict_r, verdict_nxt;
  logic                 advance;
  chk_t                 chk;
  win_res_t             wres;
  logic [SEQ_W-1:0]     newest;
  logic [ACK_W-1:0]     ack_map;
  logic [CNT_W-1:0]     rx_cnt, dup_cnt, old_cnt;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      plen_r  <= in_tdata[11:0];
      proto_r <= in_tdata[43:12];
      seq_r   <= in_tdata[59:44];
      tag_r   <= in_tdata[75:60];
      pay_r   <= in_tdata[91:76];
      peer_r  <= in_tuser;
    end
  end

  rswf_check u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .packet_length   (plen_r),
    .header_protocol (proto_r),
    .peer_match      (peer_r),
    .payload_length  (pay_r),
    .chk             (chk)
  );

  rswf_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (advance),
    .pass     (chk.pass),
    .seq      (seq_r),
    .res      (wres),
    .newest   (newest),
    .ack_map  (ack_map),
    .rx_cnt   (rx_cnt),
    .dup_cnt  (dup_cnt),
    .old_cnt  (old_cnt)
  );

  always_comb begin
    if (!chk.pass) begin
      verdict_nxt = chk.verdict;
    end else if (!wres.ok) begin
      verdict_nxt = wres.verdict;
    end else if (tag_r != '0) begin
      verdict_nxt = V_RELIABLE;
    end else if (pay_r == '0) begin
      verdict_nxt = V_KEEPALIVE;
    end else begin
      verdict_nxt = V_DELIVER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      verdict_r <= verdict_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = verdict_r;
  assign out_tdata  = {old_cnt, dup_cnt, rx_cnt, ack_map, newest};

endmodule
`default_nettype wire

// ===== rtl/core/rswf_checker.sv =====
// Port-level checker for the receive window filter, bound to the top level.
`default_nettype none
module rswf_checker
  import rswf_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic [2:0]            out_tuser
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_backpressure_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("in_tready low without an output stall");

  a_transfer_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> ##1 out_tvalid)
    else $error("accepted header produced no result");

endmodule

bind receive_sequence_window_filter rswf_checker u_rswf_checker (.*);
`default_nettype wire

// ===== tb/receive_sequence_window_filter_tb.sv =====
// Testbench for the receive sequence window filter: header checks, ack window, counters.
`default_nettype none
module receive_sequence_window_filter_tb
  import rswf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [PLEN_W-1:0]  plen;
    logic [PROTO_W-1:0] proto;
    logic               peer;
    logic [SEQ_W-1:0]   seq;
    logic [TAG_W-1:0]   tag;
    logic [PAY_W-1:0]   pay;
  } header_t;

  typedef struct {
    verdict_t           verdict;
    logic [SEQ_W-1:0]   newest;
    logic [ACK_W-1:0]   bitmap;
    logic [CNT_W-1:0]   rx_count;
    logic [CNT_W-1:0]   dup_count;
    logic [CNT_W-1:0]   old_count;
  } verdict_rec_t;

  class window_scoreboard;
    logic [PROTO_W-1:0] exp_proto;
    bit                 started;
    logic [SEQ_W-1:0]   newest;
    logic [63:0]        seen;
    logic [CNT_W-1:0]   rx_total;
    logic [CNT_W-1:0]   dup_total;
    logic [CNT_W-1:0]   old_total;
    verdict_rec_t       verdicts_due[$];
    int                 errors;

    function new();
      exp_proto   = '0;
      started     = 1'b0;
      newest      = '0;
      seen        = '0;
      rx_total    = '0;
      dup_total   = '0;
      old_total   = '0;
      errors      = 0;
    endfunction

    function bit is_newer(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
      logic [SEQ_W-1:0] ab;
      logic [SEQ_W-1:0] ba;
      ab = a - b;
      ba = b - a;
      return (a > b && ab <= 16'h8000) || (a < b && ba > 16'h8000);
    endfunction

    // 1 when the sequence is taken into the window, else why holds the rejection
    function bit fold_seq(logic [SEQ_W-1:0] seq, output verdict_t why);
      int gap;
      why = V_DELIVER;
      if (!started) begin
        started = 1'b1;
        newest  = seq;
        seen    = '0;
        return 1'b1;
      end
      if (is_newer(seq, newest)) begin
        gap = int'(16'(seq - newest));
        if (gap > WINDOW_SIZE) begin
          seen = '0;
        end else begin
          seen = ((seen << gap) | (64'd1 << (gap - 1))) & ((64'd1 << WINDOW_SIZE) - 64'd1);
        end
        newest = seq;
        return 1'b1;
      end
      if (seq == newest) begin
        dup_total++;
        why = V_DUPLICATE;
        return 1'b0;
      end
      gap = int'(16'(newest - seq));
      if (gap > WINDOW_SIZE) begin
        old_total++;
        why = V_TOO_OLD;
        return 1'b0;
      end
      if (seen[gap-1]) begin
        dup_total++;
        why = V_DUPLICATE;
        return 1'b0;
      end
      seen[gap-1] = 1'b1;
      return 1'b1;
    endfunction

    function void note_header(header_t h);
      verdict_rec_t r;
      verdict_t     why;
      if (h.plen < HEADER_BYTES || h.plen > MAX_PACKET_BYTES) begin
        why = V_MALFORMED;
      end else if (h.proto != exp_proto) begin
        why = V_WRONG_PROTOCOL;
      end else if (!h.peer) begin
        why = V_WRONG_PEER;
      end else if (HEADER_BYTES + int'(h.pay) > int'(h.plen)) begin
        why = V_MALFORMED;
      end else begin
        rx_total++;
        if (fold_seq(h.seq, why)) begin
          if (h.tag != 0) why = V_RELIABLE;
          else if (h.pay == 0) why = V_KEEPALIVE;
          else why = V_DELIVER;
        end
      end
      r.verdict   = why;
      r.newest    = newest;
      r.bitmap    = seen[ACK_W-1:0];
      r.rx_count  = rx_total;
      r.dup_count = dup_total;
      r.old_count = old_total;
      verdicts_due.insert(verdicts_due.size(), r);
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_verdict(verdict_rec_t got);
      verdict_rec_t want;
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected transfer, verdict expected none actual %0d",
                 $time, got.verdict);
        errors++;
        return;
      end
      want = verdicts_due[0];
      verdicts_due.delete(0);
      compare("verdict", 32'(want.verdict), 32'(got.verdict));
      compare("ack_newest", 32'(want.newest), 32'(got.newest));
      compare("ack_bitmap", want.bitmap, got.bitmap);
      compare("received_count", want.rx_count, got.rx_count);
      compare("duplicate_count", want.dup_count, got.dup_count);
      compare("too_old_count", want.old_count, got.old_count);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [PROTO_W-1:0]    cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [2:0]            out_tuser;

  window_scoreboard sb = new();
  bit calm = 1'b0;

  always #6 clk = ~clk;

  receive_sequence_window_filter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always @(posedge clk) begin
    verdict_rec_t got;
    if (out_tvalid && out_tready) begin
      got.verdict   = verdict_t'(out_tuser);
      got.newest    = out_tdata[15:0];
      got.bitmap    = out_tdata[47:16];
      got.rx_count  = out_tdata[79:48];
      got.dup_count = out_tdata[111:80];
      got.old_count = out_tdata[143:112];
      sb.check_verdict(got);
    end
    out_tready <= calm || ($urandom_range(99) >= 24);
  end

  function automatic header_t hdr(int plen, logic [31:0] proto, bit peer, int seq, int tag,
                                  int pay);
    header_t h;
    h.plen  = PLEN_W'(plen);
    h.proto = proto;
    h.peer  = peer;
    h.seq   = SEQ_W'(seq);
    h.tag   = TAG_W'(tag);
    h.pay   = PAY_W'(pay);
    return h;
  endfunction

  function automatic header_t random_header();
    header_t h;
    int      r;
    h.plen  = PLEN_W'($urandom_range(MAX_PACKET_BYTES, HEADER_BYTES));
    h.proto = sb.exp_proto;
    h.peer  = 1'b1;
    h.tag   = $urandom_range(1) ? '0 : TAG_W'($urandom);
    h.pay   = ($urandom_range(9) == 0) ? '0 : PAY_W'($urandom_range(h.plen - 16, 0));
    r = $urandom_range(99);
    if (r < 70) h.seq = sb.newest + SEQ_W'(int'($urandom_range(80)) - 40);
    else if (r < 80) h.seq = sb.newest + SEQ_W'(32768 + int'($urandom_range(4)) - 2);
    else if (r < 90) h.seq = sb.newest - SEQ_W'($urandom_range(200, 30));
    else h.seq = SEQ_W'($urandom);
    if ($urandom_range(99) < 22) begin
      case ($urandom_range(4))
        0: h.plen = PLEN_W'($urandom_range(4095));
        1: h.proto = $urandom;
        2: h.peer = 1'b0;
        3: h.pay = PAY_W'($urandom_range(65535, h.plen - 15));
        default: begin
          h.plen  = PLEN_W'($urandom);
          h.proto = $urandom;
          h.peer  = $urandom_range(1);
          h.tag   = TAG_W'($urandom);
          h.pay   = PAY_W'($urandom);
        end
      endcase
    end
    return h;
  endfunction

  task automatic send_header(header_t h);
    if (!calm && $urandom_range(99) < 24) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 24);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, h.pay, h.tag, h.seq, h.proto, h.plen};
    in_tuser  <= h.peer;
    do @(posedge clk); while (!in_tready);
    sb.note_header(h);
  endtask

  task automatic write_protocol(logic [PROTO_W-1:0] value);
    in_tvalid <= 1'b0;
    while (sb.verdicts_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.exp_proto = value;
  endtask

  initial begin
    logic [PROTO_W-1:0] settings[6];
    settings[0] = 32'hFFFF_FFFF;
    settings[1] = $urandom;
    settings[2] = 32'h0000_0000;
    settings[3] = $urandom;
    settings[4] = 32'h8000_0001;
    settings[5] = $urandom;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // protocol id is still at its reset value of zero
    send_header(hdr(0, 0, 1, 0, 0, 0));
    send_header(hdr(15, 0, 1, 0, 0, 0));
    send_header(hdr(4095, 0, 1, 0, 0, 0));
    send_header(hdr(2049, 0, 1, 0, 0, 0));
    send_header(hdr(100, 32'hFFFF_FFFF, 1, 0, 0, 4));
    send_header(hdr(100, 32'h8000_0000, 1, 0, 0, 4));
    send_header(hdr(100, 0, 0, 0, 0, 4));
    send_header(hdr(16, 0, 1, 0, 0, 1));
    send_header(hdr(2048, 0, 1, 0, 0, 65535));
    send_header(hdr(16, 0, 1, 65530, 0, 0));
    send_header(hdr(2048, 0, 1, 65535, 0, 2032));
    send_header(hdr(64, 0, 1, 65535, 0, 8));
    send_header(hdr(64, 0, 1, 2, 65535, 8));
    send_header(hdr(64, 0, 1, 65534, 0, 8));
    send_header(hdr(64, 0, 1, 65534, 0, 8));
    send_header(hdr(64, 0, 1, 34, 0, 8));
    send_header(hdr(64, 0, 1, 2, 0, 8));
    send_header(hdr(64, 0, 1, 1, 0, 8));
    send_header(hdr(64, 0, 1, 67, 1, 0));
    send_header(hdr(64, 0, 1, 32835, 0, 8));
    send_header(hdr(64, 0, 1, 67, 0, 8));
    send_header(hdr(2048, 0, 1, 32836, 1, 2032));

    foreach (settings[p]) begin
      write_protocol(settings[p]);
      calm = (p == 2);
      repeat (100) send_header(random_header());
    end
    calm = 1'b0;

    in_tvalid <= 1'b0;
    while (sb.verdicts_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.verdicts_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire
